>>> hw/rtl/ehp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ehp_pkg
// Shared types and constants for the Ethernet / IP / L4 header parser.
// ----------------------------------------------------------------------------
package ehp_pkg;

    localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
    localparam logic [15:0] ET_IPV4       = 16'h0800;
    localparam logic [15:0] ET_IPV6       = 16'h86DD;
    localparam logic [15:0] ET_ARP        = 16'h0806;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;

    localparam logic [15:0] HTTP_PORT_RST = 16'd80;
    localparam logic [15:0] TLS_PORT_RST  = 16'd443;
    localparam logic [15:0] DNS_PORT_RST  = 16'd53;

    localparam logic [1:0] CFG_HTTP_PORT = 2'd0;
    localparam logic [1:0] CFG_TLS_PORT  = 2'd1;
    localparam logic [1:0] CFG_DNS_PORT  = 2'd2;

    localparam logic [1:0] L3_NONE = 2'd0;
    localparam logic [1:0] L3_IPV4 = 2'd1;
    localparam logic [1:0] L3_IPV6 = 2'd2;
    localparam logic [1:0] L3_ARP  = 2'd3;

    localparam logic [1:0] L4_NONE = 2'd0;
    localparam logic [1:0] L4_TCP  = 2'd1;
    localparam logic [1:0] L4_UDP  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT_ETH = 2'd1;
    localparam logic [1:0] ST_SHORT_L3  = 2'd2;
    localparam logic [1:0] ST_SHORT_L4  = 2'd3;

    localparam logic [1:0] APP_NONE = 2'd0;
    localparam logic [1:0] APP_HTTP = 2'd1;
    localparam logic [1:0] APP_TLS  = 2'd2;
    localparam logic [1:0] APP_DNS  = 2'd3;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       is_last;
    } byte_beat_t;

    typedef struct packed {
        logic [15:0] ether_kind;
        logic [1:0]  l3_kind;
        logic [1:0]  l4_kind;
        logic [1:0]  status;
        logic [7:0]  ip_protocol;
        logic [7:0]  hop_count;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  tcp_flag_bits;
        logic [15:0] arp_opcode;
        logic [1:0]  app_class;
        logic [15:0] payload_bytes;
    } sum_beat_t;

    typedef struct packed {
        logic [15:0] frame_len;
        logic [15:0] ethertype;
        logic [5:0]  l3_hdr_bytes;
        logic [15:0] l3_len;
        logic [7:0]  proto;
        logic [7:0]  hop;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [5:0]  l4_hdr_bytes;
        logic [7:0]  flags;
        logic [15:0] udp_len;
        logic [15:0] arp_op;
    } frame_rec_t;

    typedef struct packed {
        logic       valid;
        frame_rec_t rec;
    } rec_beat_t;

endpackage

`default_nettype wire

>>> hw/rtl/ethernet_ip_l4_header_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ethernet_ip_l4_header_parser
// Streaming Ethernet / IPv4 / IPv6 / ARP / TCP / UDP header parser that
// emits one summary beat per captured frame.
//
//   channel | dir | handshake            | beat
//   byte    | in  | byte_valid/stall     | frame_byte, is_last
//   sum     | out | sum_valid/stall      | one frame summary
//   cfg     | in  | cfg_valid/ready      | port register index and value
//
// One byte beat per cycle while byte_stall is low; header fields latch as
// the byte index passes. A summary follows the last byte through a two-entry
// record queue and the output register.
// Reset clears frame state and loads the default HTTP, TLS and DNS ports.
// byte_stall rises only while the record queue is full.
// ----------------------------------------------------------------------------
module ethernet_ip_l4_header_parser #(
    parameter int MAX_FRAME_BYTES = 16384
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire ehp_pkg::byte_beat_t byte_data,
    output logic                     sum_valid,
    input  wire logic                sum_stall,
    output ehp_pkg::sum_beat_t       sum_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data
);
    import ehp_pkg::*;

    rec_beat_t q_push;
    rec_beat_t q_head;
    logic      q_full;
    logic      q_pop;

    ehp_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .q_full     (q_full),
        .q_push     (q_push)
    );

    ehp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .q_pop  (q_pop),
        .q_head (q_head)
    );

    ehp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .sum_valid (sum_valid),
        .sum_stall (sum_stall),
        .sum_data  (sum_data)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.valid |-> !q_full)
        else $error("record pushed into full queue");

    a_short_eth_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid && sum_data.status == ST_SHORT_ETH) |->
        (sum_data.ether_kind == 16'd0 && sum_data.l3_kind == L3_NONE))
        else $error("short Ethernet frame carries header fields");

    a_class_needs_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid && sum_data.payload_bytes == 16'd0) |-> (sum_data.app_class == APP_NONE))
        else $error("application class without payload");

    a_l4_needs_ip: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid && sum_data.l4_kind != L4_NONE) |->
        (sum_data.l3_kind == L3_IPV4 || sum_data.l3_kind == L3_IPV6))
        else $error("L4 kind without IP layer");

endmodule

`default_nettype wire

>>> hw/rtl/ehp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ehp_front
// Byte front end: counts frame bytes, latches header fields by position and
// pushes one frame record at the last byte.
// ----------------------------------------------------------------------------
module ehp_front #(
    parameter int MAX_FRAME_BYTES = 16384
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_stall,
    input  wire ehp_pkg::byte_beat_t byte_data,
    input  wire logic               q_full,
    output ehp_pkg::rec_beat_t      q_push
);
    import ehp_pkg::*;

    localparam logic [15:0] MaxBytes = 16'(MAX_FRAME_BYTES);

    logic [15:0] idx_reg, idx_next, idx_upd;
    logic [15:0] et_reg, et_next, et_upd;
    logic [5:0]  l3hb_reg, l3hb_next, l3hb_upd;
    logic [15:0] l3len_reg, l3len_next, l3len_upd;
    logic [7:0]  proto_reg, proto_next, proto_upd;
    logic [7:0]  hop_reg, hop_next, hop_upd;
    logic [15:0] sp_reg, sp_next, sp_upd;
    logic [15:0] dp_reg, dp_next, dp_upd;
    logic [5:0]  l4hb_reg, l4hb_next, l4hb_upd;
    logic [7:0]  flags_reg, flags_next, flags_upd;
    logic [15:0] udplen_reg, udplen_next, udplen_upd;
    logic [15:0] arp_reg, arp_next, arp_upd;

    logic        accept;
    logic        take;
    logic        l3_known;
    logic [6:0]  l4_base;
    logic [15:0] l4_off;
    logic [7:0]  b;
    logic [3:0]  ihl;
    frame_rec_t  rec;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !byte_stall;
    assign take       = accept && (idx_reg < MaxBytes);
    assign b          = byte_data.frame_byte;
    assign ihl        = b[3:0];
    assign l4_base    = 7'(ETH_HDR_BYTES) + {1'b0, l3hb_reg};
    assign l4_off     = idx_reg - {9'd0, l4_base};

    always_comb
    begin
        idx_upd    = idx_reg;
        et_upd     = et_reg;
        l3hb_upd   = l3hb_reg;
        l3len_upd  = l3len_reg;
        proto_upd  = proto_reg;
        hop_upd    = hop_reg;
        sp_upd     = sp_reg;
        dp_upd     = dp_reg;
        l4hb_upd   = l4hb_reg;
        flags_upd  = flags_reg;
        udplen_upd = udplen_reg;
        arp_upd    = arp_reg;
        l3_known   = 1'b0;
        if (take)
        begin
            idx_upd = idx_reg + 16'd1;
            if (idx_reg == 16'd12)
            begin
                et_upd[15:8] = b;
            end
            else if (idx_reg == 16'd13)
            begin
                et_upd[7:0] = b;
            end
            else if (idx_reg >= ETH_HDR_BYTES)
            begin
                case (et_reg)
                    ET_IPV4:
                    begin
                        l3_known = 1'b1;
                        case (idx_reg[4:0])
                            5'd14: l3hb_upd = (ihl < 4'd5) ? 6'd20 : {ihl, 2'b00};
                            5'd16: l3len_upd[15:8] = b;
                            5'd17: l3len_upd[7:0]  = b;
                            5'd22: hop_upd   = b;
                            5'd23: proto_upd = b;
                            default: ;
                        endcase
                        if (idx_reg[15:5] != 11'd0)
                        begin
                            l3hb_upd  = l3hb_reg;
                            l3len_upd = l3len_reg;
                            hop_upd   = hop_reg;
                            proto_upd = proto_reg;
                        end
                    end
                    ET_IPV6:
                    begin
                        l3_known = 1'b1;
                        case (idx_reg[4:0])
                            5'd14: l3hb_upd = 6'd40;
                            5'd18: l3len_upd[15:8] = b;
                            5'd19: l3len_upd[7:0]  = b;
                            5'd20: proto_upd = b;
                            5'd21: hop_upd   = b;
                            default: ;
                        endcase
                        if (idx_reg[15:5] != 11'd0)
                        begin
                            l3hb_upd  = l3hb_reg;
                            l3len_upd = l3len_reg;
                            hop_upd   = hop_reg;
                            proto_upd = proto_reg;
                        end
                    end
                    ET_ARP:
                    begin
                        if (idx_reg == 16'd20)
                        begin
                            arp_upd[15:8] = b;
                        end
                        else if (idx_reg == 16'd21)
                        begin
                            arp_upd[7:0] = b;
                        end
                    end
                    default: ;
                endcase
                if (l3_known && (l3hb_reg != 6'd0) && (idx_reg >= {9'd0, l4_base})
                    && (l4_off[15:4] == 12'd0))
                begin
                    case (l4_off[3:0])
                        4'd0: sp_upd[15:8] = b;
                        4'd1: sp_upd[7:0]  = b;
                        4'd2: dp_upd[15:8] = b;
                        4'd3: dp_upd[7:0]  = b;
                        4'd4:
                        begin
                            if (proto_reg == PROTO_UDP)
                            begin
                                udplen_upd[15:8] = b;
                            end
                        end
                        4'd5:
                        begin
                            if (proto_reg == PROTO_UDP)
                            begin
                                udplen_upd[7:0] = b;
                            end
                        end
                        4'd12:
                        begin
                            if (proto_reg == PROTO_TCP)
                            begin
                                l4hb_upd = {b[7:4], 2'b00};
                            end
                        end
                        4'd13:
                        begin
                            if (proto_reg == PROTO_TCP)
                            begin
                                flags_upd = b;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        rec.frame_len    = idx_upd;
        rec.ethertype    = et_upd;
        rec.l3_hdr_bytes = l3hb_upd;
        rec.l3_len       = l3len_upd;
        rec.proto        = proto_upd;
        rec.hop          = hop_upd;
        rec.src_port     = sp_upd;
        rec.dst_port     = dp_upd;
        rec.l4_hdr_bytes = l4hb_upd;
        rec.flags        = flags_upd;
        rec.udp_len      = udplen_upd;
        rec.arp_op       = arp_upd;
        q_push.valid     = accept && byte_data.is_last;
        q_push.rec       = rec;
    end

    always_comb
    begin
        idx_next    = idx_upd;
        et_next     = et_upd;
        l3hb_next   = l3hb_upd;
        l3len_next  = l3len_upd;
        proto_next  = proto_upd;
        hop_next    = hop_upd;
        sp_next     = sp_upd;
        dp_next     = dp_upd;
        l4hb_next   = l4hb_upd;
        flags_next  = flags_upd;
        udplen_next = udplen_upd;
        arp_next    = arp_upd;
        // drop frame state after the last beat
        if (accept && byte_data.is_last)
        begin
            idx_next    = '0;
            et_next     = '0;
            l3hb_next   = '0;
            l3len_next  = '0;
            proto_next  = '0;
            hop_next    = '0;
            sp_next     = '0;
            dp_next     = '0;
            l4hb_next   = '0;
            flags_next  = '0;
            udplen_next = '0;
            arp_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            et_reg     <= '0;
            l3hb_reg   <= '0;
            l3len_reg  <= '0;
            proto_reg  <= '0;
            hop_reg    <= '0;
            sp_reg     <= '0;
            dp_reg     <= '0;
            l4hb_reg   <= '0;
            flags_reg  <= '0;
            udplen_reg <= '0;
            arp_reg    <= '0;
        end
        else
        begin
            idx_reg    <= idx_next;
            et_reg     <= et_next;
            l3hb_reg   <= l3hb_next;
            l3len_reg  <= l3len_next;
            proto_reg  <= proto_next;
            hop_reg    <= hop_next;
            sp_reg     <= sp_next;
            dp_reg     <= dp_next;
            l4hb_reg   <= l4hb_next;
            flags_reg  <= flags_next;
            udplen_reg <= udplen_next;
            arp_reg    <= arp_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ehp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ehp_queue
// Two-entry queue of frame records between the byte front end and the
// summary back end.
// ----------------------------------------------------------------------------
module ehp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ehp_pkg::rec_beat_t q_push,
    output logic                   q_full,
    input  wire logic              q_pop,
    output ehp_pkg::rec_beat_t     q_head
);
    import ehp_pkg::*;

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);

    frame_rec_t       mem_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign q_full       = (count_reg == (PtrW+1)'(Depth));
    assign do_push      = q_push.valid && !q_full;
    assign do_pop       = q_pop && (count_reg != '0);
    assign q_head.valid = (count_reg != '0);
    assign q_head.rec   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_push.rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ehp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ehp_back
// Summary back end: holds the port registers, turns a frame record into a
// summary beat and keeps it in the output register until taken.
// ----------------------------------------------------------------------------
module ehp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire ehp_pkg::rec_beat_t q_head,
    output logic                   q_pop,
    output logic                   sum_valid,
    input  wire logic              sum_stall,
    output ehp_pkg::sum_beat_t     sum_data
);
    import ehp_pkg::*;

    logic [15:0] http_reg, http_next;
    logic [15:0] tls_reg, tls_next;
    logic [15:0] dns_reg, dns_next;
    logic        out_valid_reg, out_valid_next;
    sum_beat_t   out_reg;
    sum_beat_t   sum;
    frame_rec_t  r;
    logic        load;
    logic        v4;
    logic        tcp;
    logic [6:0]  need;
    logic [17:0] pay;
    logic [5:0]  l3_sub;

    assign cfg_ready = 1'b1;
    assign r         = q_head.rec;
    assign load      = q_head.valid && (!out_valid_reg || !sum_stall);
    assign q_pop     = load;
    assign sum_valid = out_valid_reg;
    assign sum_data  = out_reg;

    always_comb
    begin
        http_next = http_reg;
        tls_next  = tls_reg;
        dns_next  = dns_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HTTP_PORT: http_next = cfg_data;
                CFG_TLS_PORT:  tls_next  = cfg_data;
                CFG_DNS_PORT:  dns_next  = cfg_data;
                default: ;
            endcase
        end
    end

    assign v4     = (r.ethertype == ET_IPV4);
    assign tcp    = (r.proto == PROTO_TCP);
    assign need   = 7'(ETH_HDR_BYTES) + {1'b0, r.l3_hdr_bytes} + (tcp ? 7'd20 : 7'd8);
    assign l3_sub = v4 ? r.l3_hdr_bytes : 6'd0;
    assign pay    = tcp ? ({2'b00, r.l3_len} - {12'd0, l3_sub} - {12'd0, r.l4_hdr_bytes})
                        : ({2'b00, r.udp_len} - 18'd8);

    always_comb
    begin
        sum = '0;
        if (r.frame_len < ETH_HDR_BYTES)
        begin
            sum.status = ST_SHORT_ETH;
        end
        else
        begin
            sum.ether_kind = r.ethertype;
            if (r.ethertype == ET_ARP)
            begin
                sum.l3_kind = L3_ARP;
                if (r.frame_len < 16'd22)
                begin
                    sum.status = ST_SHORT_L3;
                end
                else
                begin
                    sum.arp_opcode = r.arp_op;
                end
            end
            else if (r.ethertype inside {ET_IPV4, ET_IPV6})
            begin
                sum.l3_kind = v4 ? L3_IPV4 : L3_IPV6;
                if (r.frame_len < (v4 ? 16'd34 : 16'd54))
                begin
                    sum.status = ST_SHORT_L3;
                end
                else
                begin
                    sum.ip_protocol = r.proto;
                    sum.hop_count   = r.hop;
                    if (r.proto inside {PROTO_TCP, PROTO_UDP})
                    begin
                        sum.l4_kind = tcp ? L4_TCP : L4_UDP;
                        if (r.frame_len < {9'd0, need})
                        begin
                            sum.status = ST_SHORT_L4;
                        end
                        else
                        begin
                            sum.source_port   = r.src_port;
                            sum.dest_port     = r.dst_port;
                            sum.tcp_flag_bits = tcp ? r.flags : 8'd0;
                            if (!pay[17] && (pay != 18'd0))
                            begin
                                sum.payload_bytes = (pay[16]) ? 16'hFFFF : pay[15:0];
                                if (r.src_port == http_reg || r.dst_port == http_reg)
                                begin
                                    sum.app_class = APP_HTTP;
                                end
                                else if (r.src_port == tls_reg || r.dst_port == tls_reg)
                                begin
                                    sum.app_class = APP_TLS;
                                end
                                else if (r.src_port == dns_reg || r.dst_port == dns_reg)
                                begin
                                    sum.app_class = APP_DNS;
                                end
                                else
                                begin
                                    sum.app_class = APP_NONE;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (!out_valid_reg || !sum_stall)
        begin
            out_valid_next = q_head.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            http_reg      <= HTTP_PORT_RST;
            tls_reg       <= TLS_PORT_RST;
            dns_reg       <= DNS_PORT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            http_reg      <= http_next;
            tls_reg       <= tls_next;
            dns_reg       <= dns_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire
